FILE: src/sqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared widths, command and status codes, and the cell operation type for
// the stack/queue engine.
// ----------------------------------------------------------------------------
package sqe_pkg;

	localparam int DEPTH  = 32;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		FN_PUSH = 3'd0,
		FN_DUMP = 3'd1,
		FN_PEEK = 3'd2,
		FN_POP  = 3'd3,
		FN_SWAP = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_NOARG       = 3'd1,
		STS_PEEK_EMPTY  = 3'd2,
		STS_POP_EMPTY   = 3'd3,
		STS_SWAP_SHORT  = 3'd4,
		STS_FULL        = 3'd5
	} status_t;

	// What a cell loads on the next clock edge.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_ABOVE,
		CELL_FROM_BELOW,
		CELL_FROM_TOP
	} cell_op_t;

endpackage
`default_nettype wire

FILE: src/sqe_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqe_cell
// One storage cell of the entry row; loads a new, neighbor's or top value.
// ----------------------------------------------------------------------------
module sqe_cell
	import sqe_pkg::*;
(
	input  wire logic     clk,
	input  wire cell_op_t op,
	input  wire data_t    new_val,
	input  wire data_t    above_val,
	input  wire data_t    below_val,
	input  wire data_t    top_val,
	output data_t         val
);

	data_t val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_LOAD:       val_q <= new_val;
			CELL_FROM_ABOVE: val_q <= above_val;
			CELL_FROM_BELOW: val_q <= below_val;
			CELL_FROM_TOP:   val_q <= top_val;
			default:         val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule
`default_nettype wire

FILE: src/stack_queue_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_queue_engine_core
// Bounded stack/queue of signed 32-bit entries held in a row of shift cells.
// ----------------------------------------------------------------------------
// Entries live in a row of DEPTH cells with the top entry always in cell 0.
// Push, pop, peek, swap and undefined commands give one result each; a new
// command is taken every cycle as long as the result register is drained. A
// dump of n held entries gives n results: the held part of the row rotates
// by one cell per cycle while results drain, each entry being read as it
// reaches cell 0, and after the last step the row is back in its original
// order. No command is taken during a dump. An empty dump gives a single
// result with has_data low. queue_mode may be written only while idle.
// ----------------------------------------------------------------------------
module stack_queue_engine_core
	import sqe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,   // queue_mode
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,       // [31:0] push_value
	input  wire logic [3:0]  s_tuser,       // [2:0] func, [3] arg_ok
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,       // [31:0] data
	output logic [3:0]       m_tuser,       // [0] has_data, [3:1] status
	output logic             m_tlast
);

	typedef enum logic {ST_IDLE, ST_DUMP} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic             mode_q;

	logic             out_vld_q;
	data_t            out_data_q, out_data_d;
	logic             out_has_q, out_has_d;
	status_t          out_sts_q, out_sts_d;
	logic             out_last_q, out_last_d;
	logic             out_load;

	logic             out_free, acc, dump_step;
	logic             push_go, pop_go, swap_go, rot_go;
	func_t            func;
	data_t            push_val;
	logic [CNT_W-1:0] bottom_idx;

	data_t            cell_val [DEPTH];
	cell_op_t         cell_op  [DEPTH];

	assign func     = func_t'(s_tuser[2:0]);
	assign push_val = data_t'(s_tdata);

	assign out_free  = !out_vld_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign acc       = s_tvalid && s_tready;
	assign dump_step = (state_q == ST_DUMP) && out_free;

	assign bottom_idx = fill_q - CNT_W'(1);

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		rem_d      = rem_q;
		out_load   = 1'b0;
		out_data_d = '0;
		out_has_d  = 1'b0;
		out_sts_d  = STS_OK;
		out_last_d = 1'b1;
		push_go    = 1'b0;
		pop_go     = 1'b0;
		swap_go    = 1'b0;
		rot_go     = 1'b0;
		if (acc) begin
			out_load = 1'b1;
			unique case (func)
				FN_PUSH: begin
					if (!s_tuser[3]) begin
						out_sts_d = STS_NOARG;
					end else if (fill_q == CNT_W'(DEPTH)) begin
						out_sts_d = STS_FULL;
					end else begin
						push_go = 1'b1;
						fill_d  = fill_q + CNT_W'(1);
					end
				end
				FN_DUMP: begin
					if (fill_q != '0) begin
						rot_go     = 1'b1;
						out_data_d = cell_val[0];
						out_has_d  = 1'b1;
						out_last_d = (fill_q == CNT_W'(1));
						if (fill_q != CNT_W'(1)) begin
							state_d = ST_DUMP;
							rem_d   = bottom_idx;
						end
					end
				end
				FN_PEEK: begin
					if (fill_q == '0) begin
						out_sts_d = STS_PEEK_EMPTY;
					end else begin
						out_data_d = cell_val[0];
						out_has_d  = 1'b1;
					end
				end
				FN_POP: begin
					if (fill_q == '0) begin
						out_sts_d = STS_POP_EMPTY;
					end else begin
						pop_go = 1'b1;
						fill_d = bottom_idx;
					end
				end
				FN_SWAP: begin
					if (fill_q < CNT_W'(2)) begin
						out_sts_d = STS_SWAP_SHORT;
					end else begin
						swap_go = 1'b1;
					end
				end
				default: begin
					// undefined command: plain ok result
				end
			endcase
		end else if (dump_step) begin
			out_load   = 1'b1;
			rot_go     = 1'b1;
			out_data_d = cell_val[0];
			out_has_d  = 1'b1;
			out_last_d = (rem_q == CNT_W'(1));
			rem_d      = rem_q - CNT_W'(1);
			if (rem_q == CNT_W'(1)) begin
				state_d = ST_IDLE;
			end
		end
	end

	// Per-cell operation; the rotation closes the loop at the bottom held cell.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_op[i] = CELL_HOLD;
			priority if (push_go && !mode_q) begin
				cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_ABOVE;
			end else if (push_go) begin
				if (fill_q == CNT_W'(i)) begin
					cell_op[i] = CELL_LOAD;
				end
			end else if (pop_go) begin
				cell_op[i] = CELL_FROM_BELOW;
			end else if (swap_go) begin
				if (i == 0) begin
					cell_op[i] = CELL_FROM_BELOW;
				end else if (i == 1) begin
					cell_op[i] = CELL_FROM_ABOVE;
				end
			end else if (rot_go) begin
				cell_op[i] = (bottom_idx == CNT_W'(i)) ? CELL_FROM_TOP : CELL_FROM_BELOW;
			end else begin
				cell_op[i] = CELL_HOLD;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		data_t above, below;
		if (g == 0) begin : g_first
			assign above = '0;
		end else begin : g_mid_a
			assign above = cell_val[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_mid_b
			assign below = cell_val[g+1];
		end
		sqe_cell u_cell (
			.clk       (clk),
			.op        (cell_op[g]),
			.new_val   (push_val),
			.above_val (above),
			.below_val (below),
			.top_val   (cell_val[0]),
			.val       (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			rem_q      <= '0;
			mode_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
			out_has_q  <= 1'b0;
			out_sts_q  <= STS_OK;
			out_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			rem_q   <= rem_d;
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			// Result payload: hold until the transaction completes.
			if (out_load) begin
				out_data_q <= out_data_d;
				out_has_q  <= out_has_d;
				out_sts_q  <= out_sts_d;
				out_last_q <= out_last_d;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_sts_q, out_has_q};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

FILE: bench/sqe_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_result_checker
// Watches the command and result streams of the stack/queue engine, keeps its
// own copy of the held entries, and compares every result against the oldest
// reply still awaited. Hands the mismatch count and the number of replies
// still outstanding to the bench top.
// ----------------------------------------------------------------------------
module sqe_result_checker
	import sqe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,       // [31:0] push_value
	input  wire logic [3:0]  s_tuser,       // [2:0] func, [3] arg_ok
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,       // [31:0] data
	input  wire logic [3:0]  m_tuser,       // [0] has_data, [3:1] status
	input  wire logic        m_tlast,
	output int               mismatches,
	output int               pending
);

	typedef struct packed {
		data_t   data;
		logic    has_data;
		status_t status;
		logic    last;
	} reply_t;

	data_t  held_value [DEPTH];
	int     top_slot;
	int     held_count;
	logic   queue_mode;
	reply_t awaited_replies [$];
	reply_t oldest;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Apply one command to the shadow store and queue the replies it produces.
	function automatic void predict_replies(input logic [2:0] cmd, input logic arg_ok,
			input data_t value);
		reply_t r;
		data_t  swap_tmp;
		int     next_slot;
		r.data     = '0;
		r.has_data = 1'b0;
		r.status   = STS_OK;
		r.last     = 1'b1;
		next_slot  = (top_slot + 1) % DEPTH;
		case (cmd)
		FN_PUSH: begin
			if (!arg_ok) begin
				r.status = STS_NOARG;
			end else if (held_count >= DEPTH) begin
				r.status = STS_FULL;
			end else begin
				if (queue_mode) begin
					held_value[(top_slot + held_count) % DEPTH] = value;
				end else begin
					top_slot = (top_slot + DEPTH - 1) % DEPTH;
					held_value[top_slot] = value;
				end
				held_count++;
			end
		end
		FN_DUMP: begin
			// top to bottom, one transaction per held entry
			if (held_count != 0) begin
				for (int k = 0; k < held_count; k++) begin
					r.data     = held_value[(top_slot + k) % DEPTH];
					r.has_data = 1'b1;
					r.last     = (k == held_count - 1);
					awaited_replies.push_back(r);
				end
				return;
			end
		end
		FN_PEEK: begin
			if (held_count == 0) begin
				r.status = STS_PEEK_EMPTY;
			end else begin
				r.data     = held_value[top_slot];
				r.has_data = 1'b1;
			end
		end
		FN_POP: begin
			if (held_count == 0) begin
				r.status = STS_POP_EMPTY;
			end else begin
				top_slot = next_slot;
				held_count--;
			end
		end
		FN_SWAP: begin
			if (held_count < 2) begin
				r.status = STS_SWAP_SHORT;
			end else begin
				swap_tmp              = held_value[top_slot];
				held_value[top_slot]  = held_value[next_slot];
				held_value[next_slot] = swap_tmp;
			end
		end
		default: begin
			// undefined command: acknowledged with a plain ok
		end
		endcase
		awaited_replies.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_replies.delete();
			top_slot   = 0;
			held_count = 0;
			queue_mode = 1'b0;
			mismatches = 0;
			pending   <= 0;
		end else begin
			if (cfg_wr_en)
				queue_mode = cfg_wr_data;
			// results first: a command taken at this edge cannot answer at it
			if (m_tvalid && m_tready) begin
				if (awaited_replies.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, '0);
				end else begin
					oldest = awaited_replies.pop_front();
					if (m_tdata !== oldest.data)
						report_mismatch("data", m_tdata, oldest.data);
					if (m_tuser[0] !== oldest.has_data)
						report_mismatch("has_data", 32'(m_tuser[0]),
							32'(oldest.has_data));
					if (m_tuser[3:1] !== oldest.status)
						report_mismatch("status", 32'(m_tuser[3:1]),
							32'(oldest.status));
					if (m_tlast !== oldest.last)
						report_mismatch("last", 32'(m_tlast), 32'(oldest.last));
				end
			end
			if (s_tvalid && s_tready)
				predict_replies(s_tuser[2:0], s_tuser[3], s_tdata);
			pending <= awaited_replies.size();
		end
	end

endmodule

FILE: bench/stack_queue_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_engine_core_test
// Drives commands into the stack/queue engine in both modes: a directed pass
// over empty, short and extreme cases, fill-past-full and drain-past-empty
// runs, and random command mixes with random idles on both streams, a long
// result back-pressure stretch and a stretch with no idles at all.
// ----------------------------------------------------------------------------
module stack_queue_engine_core_test
	import sqe_pkg::*;
();

	localparam logic [2:0] FN_UNUSED_LO = 3'd5;
	localparam logic [2:0] FN_UNUSED_HI = 3'd7;
	localparam int IDLE_PCT      = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	localparam int CYCLE_LIMIT   = 200000;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        s_tvalid    = 1'b0;
	logic [31:0] s_tdata     = '0;
	logic [3:0]  s_tuser     = '0;
	logic        m_tready    = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [31:0] m_tdata;
	wire  [3:0]  m_tuser;
	wire         m_tlast;

	int   mismatches;
	int   pending;
	int   cycle_count = 0;
	int   hold_left   = 0;
	logic hold_done   = 1'b0;
	logic hold_req    = 1'b0;
	logic calm        = 1'b0;

	stack_queue_engine_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	sqe_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off on request, none when calm.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready  <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return 32'hffff_ffff;
		3: return 32'h0000_0000;
		default: return $urandom();
		endcase
	endfunction

	// Offer one command and hold it until the transaction completes.
	task automatic send_cmd(input logic [2:0] fn, input logic arg_ok, input logic [31:0] value);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {arg_ok, fn};
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic quiesce_and_set_mode(input logic mode);
		s_tvalid <= 1'b0;
		wait_drained();
		// let a trailing dump rotation settle before touching the mode
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic random_commands(input int count, input int push_pct);
		int         pick;
		logic [2:0] fn;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				fn = FN_PUSH;
			else if (pick < push_pct + 8)
				fn = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
			else
				fn = 3'($urandom_range(FN_DUMP, FN_SWAP));
			send_cmd(fn, $urandom_range(0, 9) != 0, rand_value());
		end
	endtask

	// Push past capacity, look at the full store, then pop past empty.
	task automatic fill_and_drain();
		repeat (DEPTH + 2)
			send_cmd(FN_PUSH, 1'b1, rand_value());
		send_cmd(FN_SWAP, 1'($urandom_range(0, 1)), rand_value());
		send_cmd(FN_PEEK, 1'($urandom_range(0, 1)), rand_value());
		send_cmd(FN_DUMP, 1'($urandom_range(0, 1)), rand_value());
		repeat (DEPTH + 2)
			send_cmd(FN_POP, 1'($urandom_range(0, 1)), rand_value());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, short store, extreme values, undefined commands
		send_cmd(FN_DUMP, 1'b0, 32'h0000_0000);
		send_cmd(FN_PEEK, 1'b1, 32'hffff_ffff);
		send_cmd(FN_POP,  1'b0, 32'h0000_0000);
		send_cmd(FN_SWAP, 1'b1, 32'h0000_0000);
		send_cmd(FN_PUSH, 1'b0, 32'h0000_007b);
		send_cmd(FN_PUSH, 1'b1, 32'h7fff_ffff);
		send_cmd(FN_SWAP, 1'b0, 32'h0000_0000);
		send_cmd(FN_PUSH, 1'b1, 32'h8000_0000);
		send_cmd(FN_PUSH, 1'b1, 32'h0000_0000);
		send_cmd(FN_PUSH, 1'b1, 32'hffff_ffff);
		send_cmd(FN_PEEK, 1'b0, 32'h0000_0000);
		send_cmd(FN_SWAP, 1'b1, 32'h0000_0000);
		send_cmd(FN_DUMP, 1'b1, 32'h0000_0000);
		send_cmd(FN_UNUSED_LO, 1'b1, 32'h1234_5678);
		send_cmd(FN_UNUSED_LO + 3'd1, 1'b0, 32'h0000_0000);
		send_cmd(FN_UNUSED_HI, 1'b0, 32'hffff_ffff);
		send_cmd(FN_POP,  1'b1, 32'h0000_0000);
		send_cmd(FN_DUMP, 1'b0, 32'h0000_0000);
		repeat (4)
			send_cmd(FN_POP, 1'b1, 32'h0000_0000);

		quiesce_and_set_mode(1'b1);
		fill_and_drain();
		random_commands(20, 50);

		// commands back up behind a long result stall
		quiesce_and_set_mode(1'b0);
		hold_req <= 1'b1;
		random_commands(30, 55);

		quiesce_and_set_mode(1'b0);
		calm <= 1'b1;
		fill_and_drain();
		random_commands(25, 40);

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
